[hdl/i2cbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, command codes, action codes and sequence tables.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

	// command codes
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_SEND  = 3'd2;
	localparam logic [2:0] OP_RECV  = 3'd3;
	localparam logic [2:0] OP_SACK  = 3'd4;
	localparam logic [2:0] OP_RACK  = 3'd5;

	// pin and sample actions
	localparam logic [2:0] ACT_SCL0   = 3'd0;
	localparam logic [2:0] ACT_SCL1   = 3'd1;
	localparam logic [2:0] ACT_SDA0   = 3'd2;
	localparam logic [2:0] ACT_SDA1   = 3'd3;
	localparam logic [2:0] ACT_SDABIT = 3'd4;
	localparam logic [2:0] ACT_SAMPLE = 3'd5;

	// configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic [ADDR_W-1:0] REG_PHASE_LENGTH = 3'd0;
	localparam logic [15:0] PHASE_LENGTH_RST = 16'd10;

	// tick queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;

	typedef struct packed {
		logic       cmd_ok;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       ack_out;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_in;
	} result_t;

	// number of actions in each command
	function automatic logic [4:0] seq_len(input logic [2:0] cmd);
		logic [4:0] n;
		case (cmd)
			OP_START: n = 5'd4;
			OP_STOP:  n = 5'd3;
			OP_SEND:  n = 5'd25;
			OP_RECV:  n = 5'd25;
			OP_SACK:  n = 5'd3;
			default:  n = 5'd4;
		endcase
		return n;
	endfunction

	// bit number of a byte action: (idx - 1) / 3, by multiply with 11/32
	function automatic logic [2:0] bit_of(input logic [4:0] idx);
		logic [4:0] im1;
		logic [8:0] p;
		im1 = idx - 5'd1;
		p = {4'd0, im1} * 9'd11;
		return p[7:5];
	endfunction

	// step within one bit: (idx - 1) % 3
	function automatic logic [1:0] phase_of(input logic [4:0] idx);
		logic [4:0] im1;
		logic [4:0] b3;
		logic [4:0] r;
		im1 = idx - 5'd1;
		b3 = {2'd0, bit_of(idx)} * 5'd3;
		r = im1 - b3;
		return r[1:0];
	endfunction

	function automatic logic [2:0] action_of(input logic [2:0] cmd, input logic [4:0] idx);
		logic [2:0] a;
		logic [1:0] ph;
		ph = phase_of(idx);
		case (cmd)
			OP_START: begin
				case (idx[1:0])
					2'd0:    a = ACT_SDA1;
					2'd1:    a = ACT_SCL1;
					2'd2:    a = ACT_SDA0;
					default: a = ACT_SCL0;
				endcase
			end
			OP_STOP: begin
				case (idx)
					5'd0:    a = ACT_SDA0;
					5'd1:    a = ACT_SCL1;
					default: a = ACT_SDA1;
				endcase
			end
			OP_SEND: begin
				if (idx == 5'd0) begin
					a = ACT_SCL0;
				end else begin
					case (ph)
						2'd0:    a = ACT_SDABIT;
						2'd1:    a = ACT_SCL1;
						default: a = ACT_SCL0;
					endcase
				end
			end
			OP_RECV: begin
				if (idx == 5'd0) begin
					a = ACT_SDA1;
				end else begin
					case (ph)
						2'd0:    a = ACT_SCL1;
						2'd1:    a = ACT_SAMPLE;
						default: a = ACT_SCL0;
					endcase
				end
			end
			OP_SACK: begin
				case (idx)
					5'd0:    a = ACT_SDABIT;
					5'd1:    a = ACT_SCL1;
					default: a = ACT_SCL0;
				endcase
			end
			default: begin
				case (idx[1:0])
					2'd0:    a = ACT_SDA1;
					2'd1:    a = ACT_SCL1;
					2'd2:    a = ACT_SAMPLE;
					default: a = ACT_SCL0;
				endcase
			end
		endcase
		return a;
	endfunction

endpackage

[hdl/i2cbe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit engine front
// Accepts tick requests, flags usable commands and queues them for the back.
// ----------------------------------------------------------------------------
module i2cbe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              cmd_valid,
	input  logic [2:0]        opcode,
	input  logic [7:0]        tx_byte,
	input  logic              ack_out,
	input  logic              sda_in,
	output logic              q_valid,
	output i2cbe_pkg::tick_t  q_data,
	input  logic              q_take
);
	import i2cbe_pkg::*;

	tick_t         entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic          do_push;
	logic          do_pop;
	tick_t         tick;

	// opcodes six and seven never start a command
	always_comb begin
		tick.cmd_ok  = cmd_valid && (opcode <= OP_RACK);
		tick.opcode  = opcode;
		tick.tx_byte = tx_byte;
		tick.ack_out = ack_out;
		tick.sda_in  = sda_in;
	end

	assign full    = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/i2cbe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit engine back
// Runs the command sequencer one tick a cycle unless its result queue is full.
// ----------------------------------------------------------------------------
module i2cbe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        phase_length,
	input  logic               q_valid,
	input  i2cbe_pkg::tick_t   q_data,
	output logic               q_take,
	output logic               empty,
	input  logic               pop,
	output i2cbe_pkg::result_t res
);
	import i2cbe_pkg::*;

	// sequencer state
	logic        running_q;
	logic [2:0]  command_q;
	logic [4:0]  action_index_q;
	logic [15:0] tick_count_q;
	logic [7:0]  shift_byte_q;
	logic [7:0]  received_byte_q;
	logic        received_ack_q;
	logic        scl_drive_q;
	logic        sda_drive_q;

	// result queue
	result_t     out_q [2];
	logic        out_wr_q;
	logic        out_rd_q;
	logic [1:0]  out_cnt_q;

	logic        start;
	logic        run_c;
	logic [2:0]  cmd_c;
	logic [4:0]  idx_c;
	logic [15:0] tc_c;
	logic [7:0]  shift_c;
	logic [2:0]  act;
	logic [2:0]  bitn;
	logic [15:0] len_m1;
	logic [4:0]  idx_inc;
	logic        running_n;
	logic [4:0]  idx_n;
	logic [15:0] tc_n;
	logic [7:0]  shift_n;
	logic [7:0]  rx_n;
	logic        ack_n;
	logic        scl_n;
	logic        sda_n;
	logic        done;
	result_t     res_n;
	logic        do_pop;

	assign q_take = q_valid && (out_cnt_q != 2'd2);
	assign do_pop = pop && !empty;

	always_comb begin
		start   = !running_q && q_data.cmd_ok;
		run_c   = running_q || start;
		cmd_c   = start ? q_data.opcode : command_q;
		idx_c   = start ? 5'd0 : action_index_q;
		tc_c    = start ? 16'd0 : tick_count_q;
		shift_c = shift_byte_q;
		if (start) begin
			case (q_data.opcode)
				OP_SEND: shift_c = q_data.tx_byte;
				OP_SACK: shift_c = {q_data.ack_out, 7'd0};
				default: shift_c = 8'd0;
			endcase
		end
		act  = action_of(cmd_c, idx_c);
		bitn = (cmd_c == OP_SEND || cmd_c == OP_RECV) ? bit_of(idx_c) : 3'd0;
		// a phase length of zero acts as one
		len_m1 = (phase_length == 16'd0) ? 16'd0 : phase_length - 16'd1;

		scl_n   = scl_drive_q;
		sda_n   = sda_drive_q;
		shift_n = shift_c;
		ack_n   = received_ack_q;
		rx_n    = received_byte_q;
		running_n = running_q;
		idx_n   = action_index_q;
		tc_n    = tick_count_q;
		done    = 1'b0;
		idx_inc = idx_c + 5'd1;

		if (run_c) begin
			if (tc_c == 16'd0) begin
				case (act)
					ACT_SCL0:   scl_n = 1'b0;
					ACT_SCL1:   scl_n = 1'b1;
					ACT_SDA0:   sda_n = 1'b0;
					ACT_SDA1:   sda_n = 1'b1;
					ACT_SDABIT: sda_n = shift_c[3'd7 - bitn];
					default: begin
						if (cmd_c == OP_RECV) begin
							shift_n[3'd7 - bitn] = shift_c[3'd7 - bitn] | q_data.sda_in;
						end else begin
							ack_n = q_data.sda_in;
						end
					end
				endcase
			end
			if (tc_c >= len_m1) begin
				tc_n = 16'd0;
				if (idx_inc >= seq_len(cmd_c)) begin
					running_n = 1'b0;
					done      = 1'b1;
					idx_n     = 5'd0;
					if (cmd_c == OP_RECV) begin
						rx_n = shift_n;
					end
				end else begin
					running_n = 1'b1;
					idx_n     = idx_inc;
				end
			end else begin
				running_n = 1'b1;
				idx_n     = idx_c;
				tc_n      = tc_c + 16'd1;
			end
		end

		res_n.scl_level = scl_n;
		res_n.sda_level = sda_n;
		res_n.busy_res  = run_c;
		res_n.done_res  = done;
		res_n.rx_byte   = rx_n;
		res_n.ack_in    = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q       <= 1'b0;
			command_q       <= OP_START;
			action_index_q  <= '0;
			tick_count_q    <= '0;
			shift_byte_q    <= '0;
			received_byte_q <= '0;
			received_ack_q  <= 1'b0;
			scl_drive_q     <= 1'b1;
			sda_drive_q     <= 1'b1;
		end else if (q_take && run_c) begin
			running_q       <= running_n;
			command_q       <= cmd_c;
			action_index_q  <= idx_n;
			tick_count_q    <= tc_n;
			shift_byte_q    <= shift_n;
			received_byte_q <= rx_n;
			received_ack_q  <= ack_n;
			scl_drive_q     <= scl_n;
			sda_drive_q     <= sda_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			out_q[out_wr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (q_take) begin
				out_wr_q <= !out_wr_q;
			end
			if (do_pop) begin
				out_rd_q <= !out_rd_q;
			end
			case ({q_take, do_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	assign empty = (out_cnt_q == 2'd0);
	assign res   = out_q[out_rd_q];

endmodule

[hdl/i2c_master_bit_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Runs start, stop, byte and ack sequences on open-drain SCL and SDA drives.
// ----------------------------------------------------------------------------
// Usage:
//   Push one request per timing tick on the input queue port (push / full).
//   Each request carries an optional command (cmd_valid, opcode, tx_byte,
//   ack_out) and the sampled SDA level. Every request yields exactly one
//   result on the output queue port (empty / pop): pin drives, busy, a done
//   pulse on the last tick of a command, the last received byte and ack.
//   Commands offered while a sequence runs, or with opcode six or seven,
//   are dropped. Every pin action lasts phase_length ticks (register 0).
// Path: an accepted request is registered in the front queue; the sequencer
//   then retires it into the result queue, where it is on the result ports
//   and can be popped.
// Throughput: one request per cycle while neither queue is full; the
//   sequencer retires one tick a cycle while the result queue has room.
// Stalls: when pop is held low the two-entry result queue fills, the
//   sequencer holds, and the four-entry front queue absorbs requests until
//   full rises. Nothing is lost; results keep their order.
// Reset: queues empty, engine idle, both drives released, phase_length 10.
// Write phase_length only while no request is queued; a write in the middle
//   of a command applies from the next request on.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cbe_pkg::ADDR_W-1:0]  paddr,
	input  logic [i2cbe_pkg::DATA_W-1:0]  pwdata,
	output logic [i2cbe_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	// tick requests
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd_valid,
	input  logic [2:0]                    opcode,
	input  logic [7:0]                    tx_byte,
	input  logic                          ack_out,
	input  logic                          sda_in,
	// results
	output logic                          empty,
	input  logic                          pop,
	output logic                          scl_level,
	output logic                          sda_level,
	output logic                          busy_res,
	output logic                          done_res,
	output logic [7:0]                    rx_byte,
	output logic                          ack_in
);
	import i2cbe_pkg::*;

	logic        [15:0] phase_length_q;
	logic               q_valid;
	tick_t              q_data;
	logic               q_take;
	result_t            res;
	logic               cfg_wr;

	// register file: single phase length register, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_length_q <= PHASE_LENGTH_RST;
		end else if (cfg_wr && paddr == REG_PHASE_LENGTH) begin
			phase_length_q <= pwdata[15:0];
		end
	end

	// hold read data at zero outside the register
	assign prdata = (paddr == REG_PHASE_LENGTH) ? {16'd0, phase_length_q} : '0;

	// front: classify and queue tick requests
	i2cbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd_valid (cmd_valid),
		.opcode    (opcode),
		.tx_byte   (tx_byte),
		.ack_out   (ack_out),
		.sda_in    (sda_in),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_take    (q_take)
	);

	// back: advance the sequencer and queue results
	i2cbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.phase_length (phase_length_q),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_take       (q_take),
		.empty        (empty),
		.pop          (pop),
		.res          (res)
	);

	assign scl_level = res.scl_level;
	assign sda_level = res.sda_level;
	assign busy_res  = res.busy_res;
	assign done_res  = res.done_res;
	assign rx_byte   = res.rx_byte;
	assign ack_in    = res.ack_in;

`ifndef ASSERT_OFF
	// the sequencer never takes from an empty front queue
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("back took a tick from an empty queue");

	// an accepted request sits in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> q_valid)
		else $error("accepted request missing from queue");

	// a done pulse only comes with a running command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> busy_res)
		else $error("done without busy");
`endif

endmodule
